// ----- hdl/nurg_pkg.sv -----
// ----------------------------------------------------------------------------
// nurg_pkg: shared types and constants of the range generator
// Holds the controller state type, register indexes, kind and action codes,
// the draw masks for the non-uniform mode and the generator geometry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package nurg_pkg;

    // controller states, one-hot
    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_GEN_A = 6'b000010,
        ST_GEN_B = 6'b000100,
        ST_DIV   = 6'b001000,
        ST_COMB  = 6'b010000,
        ST_OUT   = 6'b100000
    } t_state;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_SEED0     = 3'd0,
        CFG_SEED1     = 3'd1,
        CFG_SEED2     = 3'd2,
        CFG_SEED3     = 3'd3,
        CFG_OFS_LOAD  = 3'd4,
        CFG_OFS_RUN   = 3'd5,
        CFG_OFS_CUST  = 3'd6,
        CFG_OFS_ITEM  = 3'd7
    } t_cfg_idx;

    // request kinds
    localparam logic [1:0] KIND_LAST_LOAD = 2'd0;
    localparam logic [1:0] KIND_LAST_RUN  = 2'd1;
    localparam logic [1:0] KIND_CUSTOMER  = 2'd2;
    localparam logic [1:0] KIND_ITEM      = 2'd3;

    // request actions
    localparam logic ACT_UNIFORM = 1'b0;
    localparam logic ACT_NURAND  = 1'b1;

    // masks for uniform(0, A), A + 1 being a power of two
    localparam int          OFS_W        = 13;
    localparam logic [12:0] MASK_LAST    = 13'h00FF;
    localparam logic [12:0] MASK_CUST    = 13'h03FF;
    localparam logic [12:0] MASK_ITEM    = 13'h1FFF;

    // generator geometry
    localparam int WORD_W  = 64;
    localparam int ROT_R   = 23;
    localparam int ROT_S   = 45;
    localparam int SHIFT_T = 17;

endpackage : nurg_pkg

`default_nettype wire

// ----- hdl/nurand_range_generator.sv -----
// ----------------------------------------------------------------------------
// nurand_range_generator: random integer in an inclusive range per request
// A xoshiro256++ source feeds a bit-serial restoring remainder unit. Uniform
// requests return draw mod span plus low; NURand requests fold a masked first
// draw into a second one, add the kind offset and reduce once more.
// ----------------------------------------------------------------------------
// A uniform request makes one pass of the 64-step radix-2 remainder unit, a
// NURand request two; an inverted range skips the generator and the unit.
// A new request is accepted only in idle, once the last result is in the output register.
// Reset (synchronous, active low): seeds 1,0,0,0, generator loaded from them,
// offsets zero, no result pending.
`timescale 1ns / 1ps
`default_nettype none

module nurand_range_generator (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // request channel
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [63:0] s_axis_tdata,   // range_low[31:0], range_high[63:32]
    input  wire  [2:0]  s_axis_tuser,   // action[0], kind[2:1]
    // result channel
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [31:0] m_axis_tdata,   // value[31:0]
    output logic        m_axis_tuser,   // range_error[0]
    // configuration write port
    input  wire         i_cfg_we,
    input  wire  [2:0]  i_cfg_addr,
    input  wire  [63:0] i_cfg_data
);
    import nurg_pkg::*;

    t_state       r_state, n_state;
    logic [63:0]  r_seed [4];
    logic [63:0]  r_gen  [4];
    logic [63:0]  gen_nxt [4];
    logic [12:0]  r_ofs_load, r_ofs_run, r_ofs_cust, r_ofs_item;

    logic         r_action, r_have_first, r_final, r_err;
    logic [5:0]   r_cnt;
    logic [63:0]  r_acc;
    logic [63:0]  r_dividend;
    logic [32:0]  r_rem;
    logic [32:0]  r_span;
    logic [31:0]  r_low;
    logic [12:0]  r_c;
    logic [12:0]  r_mask;
    logic [12:0]  r_first;

    logic         r_out_valid, r_out_err;
    logic [31:0]  r_out_data;

    logic         req_accept;
    logic [31:0]  req_low, req_high;
    logic [12:0]  sel_c, sel_mask;
    logic [63:0]  draw;
    logic [33:0]  trial, trial_sub;
    logic [31:0]  rem_plus_low;
    logic [32:0]  comb_sum;
    logic         out_load;

    assign req_low    = s_axis_tdata[31:0];
    assign req_high   = s_axis_tdata[63:32];
    assign s_axis_tready = (r_state == ST_IDLE);
    assign req_accept = s_axis_tvalid && s_axis_tready;
    assign out_load   = (r_state == ST_OUT) && (!r_out_valid || m_axis_tready);

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_err;

    // offset and mask by kind
    always_comb begin
        case (s_axis_tuser[2:1])
            KIND_LAST_LOAD: begin
                sel_c    = r_ofs_load;
                sel_mask = MASK_LAST;
            end
            KIND_LAST_RUN: begin
                sel_c    = r_ofs_run;
                sel_mask = MASK_LAST;
            end
            KIND_CUSTOMER: begin
                sel_c    = r_ofs_cust;
                sel_mask = MASK_CUST;
            end
            KIND_ITEM: begin
                sel_c    = r_ofs_item;
                sel_mask = MASK_ITEM;
            end
            default: begin
                sel_c    = r_ofs_item;
                sel_mask = MASK_ITEM;
            end
        endcase
    end

    // xoshiro256++ state step, xor, shift and rotate only
    always_comb begin
        logic [63:0] s2x, s3x;
        s2x        = r_gen[2] ^ r_gen[0];
        s3x        = r_gen[3] ^ r_gen[1];
        gen_nxt[1] = r_gen[1] ^ s2x;
        gen_nxt[0] = r_gen[0] ^ s3x;
        gen_nxt[2] = s2x ^ (r_gen[1] << SHIFT_T);
        gen_nxt[3] = {s3x[WORD_W-1-ROT_S:0], s3x[WORD_W-1:WORD_W-ROT_S]};
    end

    // second half of the output function: rotl(s0 + s3, 23) + s0
    assign draw = {r_acc[WORD_W-1-ROT_R:0], r_acc[WORD_W-1:WORD_W-ROT_R]} + r_dividend;

    // one restoring remainder step
    assign trial     = {r_rem, r_dividend[63]};
    assign trial_sub = trial - {1'b0, r_span};

    assign rem_plus_low = r_rem[31:0] + r_low;
    assign comb_sum     = {1'b0, ({19'd0, r_first} | rem_plus_low)} + {20'd0, r_c};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (req_accept) begin
                    n_state = (req_high < req_low) ? ST_OUT : ST_GEN_A;
                end
            end
            ST_GEN_A: n_state = ST_GEN_B;
            ST_GEN_B: begin
                if (r_action == ACT_NURAND && !r_have_first) begin
                    n_state = ST_GEN_A;
                end else begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (r_cnt == 6'd63) begin
                    n_state = (r_action == ACT_NURAND && !r_final) ? ST_COMB : ST_OUT;
                end
            end
            ST_COMB: n_state = ST_DIV;
            ST_OUT: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control, configuration and generator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_seed[0]    <= 64'd1;
            r_seed[1]    <= 64'd0;
            r_seed[2]    <= 64'd0;
            r_seed[3]    <= 64'd0;
            r_gen[0]     <= 64'd1;
            r_gen[1]     <= 64'd0;
            r_gen[2]     <= 64'd0;
            r_gen[3]     <= 64'd0;
            r_ofs_load   <= '0;
            r_ofs_run    <= '0;
            r_ofs_cust   <= '0;
            r_ofs_item   <= '0;
            r_cnt        <= '0;
            r_have_first <= 1'b0;
            r_final      <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;

            // configuration writes; a seed write reloads the whole generator
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_addr))
                    CFG_SEED0, CFG_SEED1, CFG_SEED2, CFG_SEED3: begin
                        r_seed[i_cfg_addr[1:0]] <= i_cfg_data;
                        for (int i = 0; i < 4; i++) begin
                            r_gen[i] <= (i_cfg_addr[1:0] == 2'(i)) ? i_cfg_data : r_seed[i];
                        end
                    end
                    CFG_OFS_LOAD: r_ofs_load <= {5'd0, i_cfg_data[7:0]};
                    CFG_OFS_RUN:  r_ofs_run  <= {5'd0, i_cfg_data[7:0]};
                    CFG_OFS_CUST: r_ofs_cust <= {3'd0, i_cfg_data[9:0]};
                    CFG_OFS_ITEM: r_ofs_item <= i_cfg_data[12:0];
                    default: ;
                endcase
            end else if (r_state == ST_GEN_A) begin
                for (int i = 0; i < 4; i++) begin
                    r_gen[i] <= gen_nxt[i];
                end
            end

            // request bookkeeping
            if (req_accept) begin
                r_have_first <= 1'b0;
                r_final      <= 1'b0;
            end
            if (r_state == ST_GEN_B) begin
                r_have_first <= 1'b1;
            end
            if (r_state == ST_COMB) begin
                r_final <= 1'b1;
            end

            // step counter of the remainder unit
            if (r_state == ST_DIV) begin
                r_cnt <= r_cnt + 6'd1;
            end else begin
                r_cnt <= '0;
            end

            // result register
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (req_accept) begin
                    r_action <= s_axis_tuser[0];
                    r_low    <= req_low;
                    r_span   <= {1'b0, req_high} - {1'b0, req_low} + 33'd1;
                    r_c      <= sel_c;
                    r_mask   <= sel_mask;
                    r_err    <= (req_high < req_low);
                    r_rem    <= '0;
                end
            end
            ST_GEN_A: begin
                r_acc      <= r_gen[0] + r_gen[3];
                r_dividend <= r_gen[0];
            end
            ST_GEN_B: begin
                if (r_action == ACT_NURAND && !r_have_first) begin
                    r_first <= draw[12:0] & r_mask;
                end else begin
                    r_dividend <= draw;
                    r_rem      <= '0;
                end
            end
            ST_DIV: begin
                // restoring step: keep the trial remainder if span fits
                if (trial >= {1'b0, r_span}) begin
                    r_rem <= trial_sub[32:0];
                end else begin
                    r_rem <= trial[32:0];
                end
                r_dividend <= {r_dividend[62:0], 1'b0};
            end
            ST_COMB: begin
                r_dividend <= {31'd0, comb_sum};
                r_rem      <= '0;
            end
            ST_OUT: begin
                if (out_load) begin
                    r_out_data <= r_err ? 32'd0 : rem_plus_low;
                    r_out_err  <= r_err;
                end
            end
            default: ;
        endcase
    end

`ifndef SYNTH
    // partial remainder always stays below the divisor
    a_rem_below_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_rem < r_span))
        else $error("remainder reached span");

    // an error result carries a zero value
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == 32'd0))
        else $error("error result with nonzero value");

    // an inverted range skips the generator
    a_err_direct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req_accept && (req_high < req_low)) |=> (r_state == ST_OUT))
        else $error("inverted range did not go straight to output");

    // the step counter only runs inside the remainder unit
    a_cnt_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != 6'd0) |-> (r_state == ST_DIV))
        else $error("step counter running outside division");
`endif

endmodule : nurand_range_generator

`default_nettype wire
